### rtl/tmhq_pkg.sv
package tmhq_pkg;

   localparam int unsigned ID_W = 6;
   localparam int unsigned ID_COUNT = 64;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_POP    = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_NEGATIVE = 3'd2,
      ST_FULL     = 3'd3,
      ST_BUSY     = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] now;
      logic [5:0]  timer_id;
      logic signed [31:0] period;
      logic [31:0] tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  out_id;
      logic [30:0] out_period;
      logic [31:0] out_tag;
      logic [30:0] latency;
   } rsp_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_RM_READ,
      FSM_RM_CHECK,
      FSM_UP_READ,
      FSM_UP_CMP,
      FSM_DN_READ,
      FSM_DN_READ2,
      FSM_DN_CMP,
      FSM_PLACE,
      FSM_RESPOND
   } fsm_type;

   // True when a is strictly later than b, wrap-aware.
   function automatic logic later(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] d;
      d = a - b;
      return (d != 64'd0) && !d[63];
   endfunction

endpackage

### rtl/timer_min_heap_queue_core.sv
// Sequencing: a status-only transaction passes DECODE and RESPOND before
// its result shows; a sift adds UP_READ and UP_CMP per level walked up and
// DN_READ, DN_READ2 and DN_CMP per level walked down, plus the last-entry
// read, parent check and final write. Worst case is a pop from a full heap.
// Throughput: one transaction in flight; the next is accepted the cycle after
// the result is taken. Every sift step is a read of the shared heap memory.
// Reset: synchronous, active high; clears the count and all pending bits.
module timer_min_heap_queue_core #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tmhq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tmhq_pkg::rsp_type rsp_data
);
   import tmhq_pkg::*;

   localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned HW = 64 + ID_W;

   fsm_type          state_ff, state_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [ID_COUNT-1:0] pend_ff, pend_in;
   logic [PW:0]      hole_ff, hole_in;
   logic [PW:0]      kid_ff, kid_in;
   logic [63:0]      key_dl_ff, key_dl_in;
   logic [ID_W-1:0]  key_own_ff, key_own_in;
   logic [HW-1:0]    kid_a_ff, kid_a_in;
   logic             down_ff, down_in;

   // heap memory: deadline and owner per slot
   logic             h_we;
   logic [PW-1:0]    h_waddr, h_raddr;
   logic [HW-1:0]    h_wdata, h_rdata;
   // per-id memories
   logic             e_we;
   logic [ID_W-1:0]  e_addr_w, e_addr_r;
   logic [62:0]      e_wdata, e_rdata;
   logic             p_we;
   logic [ID_W-1:0]  p_waddr, p_raddr;
   logic [PW-1:0]    p_wdata, p_rdata;

   tmhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
      .clock(clock), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
      .rd_addr(h_raddr), .rd_data(h_rdata));
   tmhq_ram #(.WIDTH(63), .DEPTH(ID_COUNT)) u_entry (
      .clock(clock), .wr_en(e_we), .wr_addr(e_addr_w), .wr_data(e_wdata),
      .rd_addr(e_addr_r), .rd_data(e_rdata));
   tmhq_ram #(.WIDTH(PW), .DEPTH(ID_COUNT)) u_pos (
      .clock(clock), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
      .rd_addr(p_raddr), .rd_data(p_rdata));

   assign req_ready = (state_ff == FSM_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         pend_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
      end
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      hole_ff    <= hole_in;
      kid_ff     <= kid_in;
      key_dl_ff  <= key_dl_in;
      key_own_ff <= key_own_in;
      kid_a_ff   <= kid_a_in;
      down_ff    <= down_in;
   end

   logic [63:0]   diff;
   logic [PW:0]   parent;
   logic [PW:0]   kid_next;
   logic [63:0]   h_dl;
   logic [ID_W-1:0] h_own;
   logic [CW-1:0] cnt_m1;
   logic [HW-1:0] best;
   logic [PW:0]   best_idx;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      hole_in      = hole_ff;
      kid_in       = kid_ff;
      key_dl_in    = key_dl_ff;
      key_own_in   = key_own_ff;
      kid_a_in     = kid_a_ff;
      down_in      = down_ff;
      h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
      e_we = 1'b0; e_addr_w = req_ff.timer_id; e_addr_r = req_ff.timer_id;
      e_wdata = {req_ff.period[30:0], req_ff.tag};
      p_we = 1'b0; p_waddr = key_own_ff; p_wdata = hole_ff[PW-1:0];
      p_raddr = req_ff.timer_id;
      h_dl  = h_rdata[HW-1:ID_W];
      h_own = h_rdata[ID_W-1:0];
      diff  = '0;
      cnt_m1 = count_ff - CW'(1);
      parent = (hole_ff - (PW+1)'(1)) >> 1;
      kid_next = '0;
      best = '0;
      best_idx = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         FSM_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               rsp_in = '0;
               state_in = FSM_DECODE;
            end
            // root read for pop and query
            h_raddr = '0;
            e_addr_r = req_data.timer_id;
            p_raddr = req_data.timer_id;
         end
         FSM_DECODE: begin
            state_in = FSM_RESPOND;
            case (cmd_type'(req_ff.command))
               CMD_ADD: begin
                  if (req_ff.period[31]) begin
                     rsp_in.status = ST_NEGATIVE;
                  end else if (pend_ff[req_ff.timer_id]) begin
                     rsp_in.status = ST_BUSY;
                  end else if (count_ff >= CW'(CAPACITY)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     e_we = 1'b1;
                     pend_in[req_ff.timer_id] = 1'b1;
                     count_in = count_ff + CW'(1);
                     hole_in = (PW+1)'(count_ff);
                     key_dl_in = req_ff.now + {33'd0, req_ff.period[30:0]};
                     key_own_in = req_ff.timer_id;
                     state_in = FSM_UP_READ;
                  end
               end
               CMD_REMOVE: begin
                  if (!pend_ff[req_ff.timer_id] || count_ff == '0) begin
                     rsp_in.status = ST_BUSY;
                  end else begin
                     pend_in[req_ff.timer_id] = 1'b0;
                     count_in = cnt_m1;
                     // hole index arrives from position memory next cycle
                     h_raddr = PW'(cnt_m1);
                     state_in = FSM_RM_READ;
                  end
               end
               CMD_POP: begin
                  diff = h_dl - req_ff.now;
                  if (count_ff == '0 || (diff != '0 && !diff[63])) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     e_addr_r = h_own;
                     rsp_in.out_id = h_own;
                     pend_in[h_own] = 1'b0;
                     count_in = cnt_m1;
                     hole_in = '0;
                     h_raddr = PW'(cnt_m1);
                     state_in = FSM_RM_READ;
                  end
               end
               default: begin
                  diff = h_dl - req_ff.now;
                  if (count_ff == '0) begin
                     rsp_in.status = ST_EMPTY;
                  end else if (diff[63]) begin
                     rsp_in.latency = '0;
                  end else if (diff > 64'h7FFF_FFFF) begin
                     rsp_in.latency = 31'h7FFF_FFFF;
                  end else begin
                     rsp_in.latency = diff[30:0];
                  end
               end
            endcase
         end
         FSM_RM_READ: begin
            // last entry is key; decide hole
            key_dl_in = h_dl;
            key_own_in = h_own;
            if (cmd_type'(req_ff.command) == CMD_POP) begin
               rsp_in.out_period = e_rdata[62:32];
               rsp_in.out_tag = e_rdata[31:0];
               if (count_ff == '0) begin
                  state_in = FSM_RESPOND;
               end else begin
                  down_in = 1'b1;
                  state_in = FSM_DN_READ;
               end
            end else begin
               if ({1'b0, p_rdata} >= (PW+1)'(count_ff)) begin
                  hole_in = (PW+1)'(count_ff);
                  state_in = FSM_RESPOND;
               end else begin
                  hole_in = {1'b0, p_rdata};
                  if (p_rdata == '0) begin
                     state_in = FSM_DN_READ;
                  end else begin
                     h_raddr = PW'(({1'b0, p_rdata} - (PW+1)'(1)) >> 1);
                     state_in = FSM_RM_CHECK;
                  end
               end
            end
         end
         FSM_RM_CHECK: begin
            if (later(h_dl, key_dl_ff)) begin
               state_in = FSM_UP_READ;
            end else begin
               state_in = FSM_DN_READ;
            end
         end
         FSM_UP_READ: begin
            if (hole_ff == '0) begin
               state_in = FSM_PLACE;
            end else begin
               h_raddr = PW'(parent);
               state_in = FSM_UP_CMP;
            end
         end
         FSM_UP_CMP: begin
            if (later(h_dl, key_dl_ff)) begin
               h_we = 1'b1;
               h_waddr = PW'(hole_ff);
               h_wdata = h_rdata;
               p_we = 1'b1;
               p_waddr = h_own;
               p_wdata = PW'(hole_ff);
               hole_in = parent;
               state_in = FSM_UP_READ;
            end else begin
               state_in = FSM_PLACE;
            end
         end
         FSM_DN_READ: begin
            kid_next = (hole_ff + (PW+1)'(1)) << 1;
            kid_in = kid_next;
            if (kid_next > (PW+1)'(count_ff)) begin
               state_in = FSM_PLACE;
            end else begin
               h_raddr = PW'(kid_next - (PW+1)'(1));
               state_in = FSM_DN_READ2;
            end
         end
         FSM_DN_READ2: begin
            kid_a_in = h_rdata;
            if (kid_ff == (PW+1)'(count_ff)) begin
               kid_in = kid_ff - (PW+1)'(1);
               state_in = FSM_DN_CMP;
               kid_a_in = h_rdata;
               down_in = 1'b0;
            end else begin
               h_raddr = PW'(kid_ff);
               down_in = 1'b1;
               state_in = FSM_DN_CMP;
            end
         end
         FSM_DN_CMP: begin
            best = kid_a_ff;
            best_idx = kid_ff - (PW+1)'(1);
            if (!down_ff) begin
               best_idx = kid_ff;
            end else if (!later(h_dl, kid_a_ff[HW-1:ID_W])) begin
               best = h_rdata;
               best_idx = kid_ff;
            end
            if (!later(key_dl_ff, best[HW-1:ID_W])) begin
               state_in = FSM_PLACE;
            end else begin
               h_we = 1'b1;
               h_waddr = PW'(hole_ff);
               h_wdata = best;
               p_we = 1'b1;
               p_waddr = best[ID_W-1:0];
               p_wdata = PW'(hole_ff);
               hole_in = best_idx;
               state_in = FSM_DN_READ;
            end
            down_in = 1'b1;
         end
         FSM_PLACE: begin
            h_we = 1'b1;
            h_waddr = PW'(hole_ff);
            h_wdata = {key_dl_ff, key_own_ff};
            p_we = 1'b1;
            state_in = FSM_RESPOND;
         end
         FSM_RESPOND: begin
            rsp_valid_in = 1'b1;
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

### rtl/tmhq_ram.sv
module tmhq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/tmhq_checker.sv
module tmhq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tmhq_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tmhq_pkg::rsp_type rsp_data
);
   import tmhq_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // no new request while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");

   // accepted request yields no immediate result
   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result too early");

   // status stays in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_BUSY)
      else $error("bad status code");

endmodule

bind timer_min_heap_queue_core tmhq_checker u_tmhq_checker (.*);
